>>> design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is held.
`define PSCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PSCV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/pscv_pkg.sv
// ----------------------------------------------------------------------------
// PCM sample format converter package
// Format codes, register indexes, widths and format decode helpers.
// ----------------------------------------------------------------------------
package pscv_pkg;

  localparam int SAMPLE_W   = 48;
  localparam int WORD_W     = 32;
  localparam int FMT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_DIR      = 2'd1;

  localparam logic DIR_UNPACK = 1'b0;
  localparam logic DIR_PACK   = 1'b1;

  localparam logic [FMT_W-1:0] SF_S8      = 4'd0;
  localparam logic [FMT_W-1:0] SF_U8      = 4'd1;
  localparam logic [FMT_W-1:0] SF_S16_LE  = 4'd2;
  localparam logic [FMT_W-1:0] SF_U16_LE  = 4'd3;
  localparam logic [FMT_W-1:0] SF_S24_LE  = 4'd4;
  localparam logic [FMT_W-1:0] SF_U24_LE  = 4'd5;
  localparam logic [FMT_W-1:0] SF_S32_LE  = 4'd6;
  localparam logic [FMT_W-1:0] SF_U32_LE  = 4'd7;
  localparam logic [FMT_W-1:0] SF_S16_BE  = 4'd8;
  localparam logic [FMT_W-1:0] SF_U16_BE  = 4'd9;
  localparam logic [FMT_W-1:0] SF_S24_BE  = 4'd10;
  localparam logic [FMT_W-1:0] SF_U24_BE  = 4'd11;
  localparam logic [FMT_W-1:0] SF_S32_BE  = 4'd12;
  localparam logic [FMT_W-1:0] SF_U32_BE  = 4'd13;
  localparam logic [FMT_W-1:0] FMT_RESET  = SF_S16_LE;

  // Offset-binary midpoints, and the positive full scale of each depth.
  localparam logic [WORD_W-1:0] OFFSET_8  = 32'h0000_0080;
  localparam logic [WORD_W-1:0] OFFSET_16 = 32'h0000_8000;
  localparam logic [WORD_W-1:0] OFFSET_24 = 32'h0080_0000;
  localparam logic [WORD_W-1:0] OFFSET_32 = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MAX_8     = 32'h0000_007f;
  localparam logic [WORD_W-1:0] MAX_16    = 32'h0000_7fff;
  localparam logic [WORD_W-1:0] MAX_24    = 32'h007f_ffff;
  localparam logic [WORD_W-1:0] MAX_32    = 32'h7fff_ffff;

  typedef enum logic [1:0] {
    DEPTH_8,
    DEPTH_16,
    DEPTH_24,
    DEPTH_32
  } depth_t;

  typedef struct packed {
    logic   known;
    depth_t depth;
    logic   offs;
    logic   big;
  } fmt_t;

  function automatic fmt_t mk_fmt(input depth_t d, input logic offs, input logic big);
    fmt_t r;
    r.known = 1'b1;
    r.depth = d;
    r.offs  = offs;
    r.big   = big;
    return r;
  endfunction

  function automatic fmt_t decode_fmt(input logic [FMT_W-1:0] f);
    fmt_t r;
    r = '0;
    unique case (f)
      SF_S8:     r = mk_fmt(DEPTH_8,  1'b0, 1'b0);
      SF_U8:     r = mk_fmt(DEPTH_8,  1'b1, 1'b0);
      SF_S16_LE: r = mk_fmt(DEPTH_16, 1'b0, 1'b0);
      SF_U16_LE: r = mk_fmt(DEPTH_16, 1'b1, 1'b0);
      SF_S24_LE: r = mk_fmt(DEPTH_24, 1'b0, 1'b0);
      SF_U24_LE: r = mk_fmt(DEPTH_24, 1'b1, 1'b0);
      SF_S32_LE: r = mk_fmt(DEPTH_32, 1'b0, 1'b0);
      SF_U32_LE: r = mk_fmt(DEPTH_32, 1'b1, 1'b0);
      SF_S16_BE: r = mk_fmt(DEPTH_16, 1'b0, 1'b1);
      SF_U16_BE: r = mk_fmt(DEPTH_16, 1'b1, 1'b1);
      SF_S24_BE: r = mk_fmt(DEPTH_24, 1'b0, 1'b1);
      SF_U24_BE: r = mk_fmt(DEPTH_24, 1'b1, 1'b1);
      SF_S32_BE: r = mk_fmt(DEPTH_32, 1'b0, 1'b1);
      SF_U32_BE: r = mk_fmt(DEPTH_32, 1'b1, 1'b1);
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Keep only the container bits of a word.
  function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                  input depth_t d);
    logic [WORD_W-1:0] r;
    case (d)
      DEPTH_8:  r = {24'd0, w[7:0]};
      DEPTH_16: r = {16'd0, w[15:0]};
      default:  r = w;
    endcase
    return r;
  endfunction

  // Byte swap over the container; 24 bit samples sit in a 32 bit container.
  function automatic logic [WORD_W-1:0] swap_word(input logic [WORD_W-1:0] w,
                                                  input depth_t d);
    logic [WORD_W-1:0] r;
    case (d)
      DEPTH_8:  r = {24'd0, w[7:0]};
      DEPTH_16: r = {16'd0, w[7:0], w[15:8]};
      default:  r = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] offset_of(input fmt_t fmt);
    logic [WORD_W-1:0] r;
    r = '0;
    if (fmt.offs) begin
      case (fmt.depth)
        DEPTH_8:  r = OFFSET_8;
        DEPTH_16: r = OFFSET_16;
        DEPTH_24: r = OFFSET_24;
        default:  r = OFFSET_32;
      endcase
    end
    return r;
  endfunction

endpackage

>>> design/pscv_unpack.sv
// ----------------------------------------------------------------------------
// Unpack path
// Container word to normalized fixed point: swap, remove offset, scale, clamp.
// ----------------------------------------------------------------------------
module pscv_unpack import pscv_pkg::*; #(
  parameter int NORM_FRACTION_BITS = 32
) (
  input  fmt_t                fmt,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0] norm
);

  localparam int SH8  = NORM_FRACTION_BITS - 7;
  localparam int SH16 = NORM_FRACTION_BITS - 15;
  localparam int SH24 = NORM_FRACTION_BITS - 23;
  localparam int SH32 = NORM_FRACTION_BITS - 31;
  // 24 bit samples keep all 32 container bits, so they need the most headroom
  localparam int RAW_W = WORD_W + SH24 + 1;
  localparam int EXT_W = (RAW_W > SAMPLE_W + 1) ? RAW_W : SAMPLE_W + 1;

  localparam logic signed [EXT_W-1:0] SAT_HI =
    {{(EXT_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_LO =
    {{(EXT_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic [WORD_W-1:0]       word;
  logic [WORD_W-1:0]       diff;
  logic signed [EXT_W-1:0] sext;
  logic signed [EXT_W-1:0] scaled;

  always_comb begin
    word = mask_word(sample[WORD_W-1:0], fmt.depth);
    if (fmt.big) begin
      word = swap_word(word, fmt.depth);
    end
    diff = word - offset_of(fmt);

    case (fmt.depth)
      DEPTH_8: begin
        sext   = {{(EXT_W-8){diff[7]}}, diff[7:0]};
        scaled = sext <<< SH8;
      end
      DEPTH_16: begin
        sext   = {{(EXT_W-16){diff[15]}}, diff[15:0]};
        scaled = sext <<< SH16;
      end
      DEPTH_24: begin
        sext   = {{(EXT_W-WORD_W){diff[WORD_W-1]}}, diff};
        scaled = sext <<< SH24;
      end
      default: begin
        sext   = {{(EXT_W-WORD_W){diff[WORD_W-1]}}, diff};
        scaled = sext <<< SH32;
      end
    endcase

    if (scaled > SAT_HI) begin
      norm = SAT_HI[SAMPLE_W-1:0];
    end else if (scaled < SAT_LO) begin
      norm = SAT_LO[SAMPLE_W-1:0];
    end else begin
      norm = scaled[SAMPLE_W-1:0];
    end
  end

endmodule

>>> design/pscv_pack.sv
// ----------------------------------------------------------------------------
// Pack path
// Normalized fixed point to container word: scale, round, saturate, offset,
// wrap and swap.
// ----------------------------------------------------------------------------
module pscv_pack import pscv_pkg::*; #(
  parameter int NORM_FRACTION_BITS = 32
) (
  input  fmt_t                fmt,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0] word_out
);

  localparam int SUM_W = SAMPLE_W + 1;
  localparam int SH8   = NORM_FRACTION_BITS - 7;
  localparam int SH16  = NORM_FRACTION_BITS - 15;
  localparam int SH24  = NORM_FRACTION_BITS - 23;
  localparam int SH32  = NORM_FRACTION_BITS - 31;
  // Half an LSB of the target depth; zero when there is no shift
  localparam logic [SUM_W-1:0] HALF8  = (SUM_W'(1) << SH8)  >> 1;
  localparam logic [SUM_W-1:0] HALF16 = (SUM_W'(1) << SH16) >> 1;
  localparam logic [SUM_W-1:0] HALF24 = (SUM_W'(1) << SH24) >> 1;
  localparam logic [SUM_W-1:0] HALF32 = (SUM_W'(1) << SH32) >> 1;

  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]    half;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    rounded;
  logic [WORD_W-1:0]   pos_max;
  logic [WORD_W-1:0]   lim;
  logic [WORD_W-1:0]   clip;
  logic [WORD_W-1:0]   word;

  always_comb begin
    neg = sample[SAMPLE_W-1];
    mag = neg ? (~sample + SAMPLE_W'(1)) : sample;

    case (fmt.depth)
      DEPTH_8:  begin half = HALF8;  pos_max = MAX_8;  end
      DEPTH_16: begin half = HALF16; pos_max = MAX_16; end
      DEPTH_24: begin half = HALF24; pos_max = MAX_24; end
      default:  begin half = HALF32; pos_max = MAX_32; end
    endcase

    sum = {1'b0, mag} + half;
    case (fmt.depth)
      DEPTH_8:  rounded = sum >> SH8;
      DEPTH_16: rounded = sum >> SH16;
      DEPTH_24: rounded = sum >> SH24;
      default:  rounded = sum >> SH32;
    endcase

    // Negative side reaches one step further than the positive side
    lim = neg ? (pos_max + WORD_W'(1)) : pos_max;
    if (rounded > {{(SUM_W-WORD_W){1'b0}}, lim}) begin
      clip = lim;
    end else begin
      clip = rounded[WORD_W-1:0];
    end

    word = neg ? (WORD_W'(0) - clip) : clip;
    word = mask_word(word + offset_of(fmt), fmt.depth);
    if (fmt.big) begin
      word = swap_word(word, fmt.depth);
    end
    word_out = {{(SAMPLE_W-WORD_W){1'b0}}, word};
  end

endmodule

>>> design/pcm_sample_format_converter.sv
// Path: an accepted sample enters the input register; its result then enters
// the result register, which drives out_valid. Ready passes back through both.
// Throughput: one sample per cycle while out_ready is high; an input register
// feeds the format logic and a result register drives the output.
// Reset (synchronous, rst_n low): pipeline empties, sample_format returns to
// s16 little-endian, conversion_direction to unpack.
// ----------------------------------------------------------------------------
// PCM sample format converter
// Converts PCM container words to and from normalized fixed point samples.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter import pscv_pkg::*; #(
  parameter int NORM_FRACTION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample_in,
  input  logic                  in_last_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample_out,
  output logic                  out_last_out
);

  logic [FMT_W-1:0]    fmt_r, fmt_nxt;
  logic                dir_r, dir_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_W-1:0] s1_sample_r, s1_sample_nxt;
  logic                s1_last_r, s1_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                out_last_r, out_last_nxt;

  logic                out_free;
  logic                in_xfer;
  fmt_t                fmt;
  logic [SAMPLE_W-1:0] unpack_res;
  logic [SAMPLE_W-1:0] pack_res;
  logic [SAMPLE_W-1:0] result;

  assign fmt = decode_fmt(fmt_r);

  pscv_unpack #(.NORM_FRACTION_BITS(NORM_FRACTION_BITS)) u_unpack (
    .fmt    (fmt),
    .sample (s1_sample_r),
    .norm   (unpack_res)
  );

  pscv_pack #(.NORM_FRACTION_BITS(NORM_FRACTION_BITS)) u_pack (
    .fmt      (fmt),
    .sample   (s1_sample_r),
    .word_out (pack_res)
  );

  always_comb begin
    if (!fmt.known) begin
      result = '0;
    end else if (dir_r == DIR_PACK) begin
      result = pack_res;
    end else begin
      result = unpack_res;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    fmt_nxt = fmt_r;
    dir_nxt = dir_r;
    if (cfg_we) begin
      if (cfg_index == CFG_SAMPLE_FORMAT) begin
        fmt_nxt = cfg_data[FMT_W-1:0];
      end else if (cfg_index == CFG_CONV_DIR) begin
        dir_nxt = cfg_data[0];
      end
    end

    s1_valid_nxt  = in_xfer || (s1_valid_r && !out_free);
    s1_sample_nxt = in_xfer ? in_sample_in : s1_sample_r;
    s1_last_nxt   = in_xfer ? in_last_in : s1_last_r;

    out_valid_nxt  = out_free ? s1_valid_r : 1'b1;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    if (out_free && s1_valid_r) begin
      out_sample_nxt = result;
      out_last_nxt   = s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RESET;
      dir_r       <= DIR_UNPACK;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      dir_r       <= dir_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample_r  <= s1_sample_nxt;
    s1_last_r    <= s1_last_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

endmodule

>>> design/pcm_sample_format_converter_chk.sv
// ----------------------------------------------------------------------------
// PCM sample format converter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcm_sample_format_converter_chk import pscv_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SAMPLE_W-1:0]   out_sample_out,
  input logic                  out_last_out
);

  // Shadow of the direction register, as seen on the config port
  logic dir_r, dir_nxt;

  always_comb begin
    dir_nxt = dir_r;
    if (cfg_we && cfg_index == CFG_CONV_DIR) begin
      dir_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_UNPACK;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  `PSCV_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `PSCV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_last_out), "stalled result changed")
  `PSCV_ASSERT(a_in_reaches_out, in_valid && in_ready |-> ##2 out_valid, "accepted sample did not reach the output")
  `PSCV_ASSERT(a_pack_upper_zero, out_valid && dir_r == DIR_PACK |-> out_sample_out[SAMPLE_W-1:WORD_W] == '0, "packed word has upper bits set")

endmodule

bind pcm_sample_format_converter pcm_sample_format_converter_chk u_chk (.*);
